FILE: src/bba_pkg.sv
`timescale 1ns / 1ps

package bba_pkg;

  localparam int SIZE_W   = 32;
  localparam int OFFS_W   = 16;
  localparam int BANK_W   = 8;
  localparam int NBANK_W  = BANK_W + 1;
  localparam int PROD_W   = 2 * SIZE_W;
  localparam int EBANK_W  = SIZE_W + 1;
  localparam int CNT_W    = $clog2(SIZE_W);
  localparam int CFG_W    = OFFS_W;

  localparam logic [OFFS_W-1:0] BANK_SIZE_RST  = 16'd64000;
  localparam logic [OFFS_W-1:0] BANK_SIZE_MIN  = 16'd2;
  localparam logic [BANK_W-1:0] FIRST_BANK_RST = 8'd5;
  localparam logic [BANK_W-1:0] LAST_BANK_RST  = 8'd255;

  typedef enum logic [1:0] {
    ST_GRANTED   = 2'd0,
    ST_ZERO      = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_BANK_SIZE  = 2'd0,
    CFG_FIRST_BANK = 2'd1,
    CFG_LAST_BANK  = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    OP_PLAIN = 1'b0,
    OP_ARRAY = 1'b1
  } op_t;

endpackage

FILE: src/bba_req_if.sv
`timescale 1ns / 1ps

interface bba_req_if;
  import bba_pkg::*;

  logic              valid;
  logic              ready;
  logic              operation;
  logic [SIZE_W-1:0] elem_size;
  logic [SIZE_W-1:0] elem_count;

  modport source (output valid, operation, elem_size, elem_count, input ready);
  modport sink   (input valid, operation, elem_size, elem_count, output ready);
endinterface

FILE: src/bba_rsp_if.sv
`timescale 1ns / 1ps

interface bba_rsp_if;
  import bba_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [OFFS_W-1:0] block_offset;
  logic [BANK_W-1:0] block_bank;

  modport source (output valid, status, block_offset, block_bank, input ready);
  modport sink   (input valid, status, block_offset, block_bank, output ready);
endinterface

FILE: src/banked_bump_allocator_core.sv
`timescale 1ns / 1ps
// sequence: request checks, then for count times size the product and its overflow check,
//   then clamp and bump; a block that spans banks also runs the 32-step bank-size divider
// requests: accepted only in idle, once the last result is in the output register
// reset: synchronous active-low clears the position, the started flag and the output;
//   config comes up as 64000 words per bank, first bank 5, last bank 255
module banked_bump_allocator_core (
  input  logic                   clk,
  input  logic                   rst_n,
  bba_req_if.sink                in_req,
  bba_rsp_if.source              out_rsp,
  input  logic                   cfg_we,
  input  bba_pkg::cfg_idx_t      cfg_index,
  input  logic [bba_pkg::CFG_W-1:0] cfg_wdata
);
  import bba_pkg::*;

  // one-hot sequencer states
  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,  // waiting for a request transfer
    S_CHECK = 10'b00_0000_0010,  // zero operand checks, first-use start
    S_MUL   = 10'b00_0000_0100,  // count times size into product register
    S_MCHK  = 10'b00_0000_1000,  // overflow check of the product
    S_PREP  = 10'b00_0001_0000,  // clamp bank size, start offset, room in bank
    S_BUMP  = 10'b00_0010_0000,  // fits in bank, fills bank, or spans banks
    S_DIV   = 10'b00_0100_0000,  // restoring divide, one quotient bit a cycle
    S_QUO   = 10'b00_1000_0000,  // end bank from quotient
    S_FIN   = 10'b01_0000_0000,  // last bank check and commit
    S_DONE  = 10'b10_0000_0000   // hand result to output register
  } state_t;

  state_t state_r, state_nxt;

  // config registers
  logic [OFFS_W-1:0] bank_size_r, bank_size_nxt;
  logic [BANK_W-1:0] first_bank_r, first_bank_nxt;
  logic [BANK_W-1:0] last_bank_r, last_bank_nxt;

  // allocation position
  logic [NBANK_W-1:0] bank_r, bank_nxt;
  logic [OFFS_W-1:0]  offset_r, offset_nxt;
  logic               started_r, started_nxt;

  // request and working registers
  logic               op_r, op_nxt;
  logic [SIZE_W-1:0]  size_r, size_nxt;
  logic [SIZE_W-1:0]  count_r, count_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [OFFS_W-1:0]  bw_r, bw_nxt;
  logic [OFFS_W-1:0]  soff_r, soff_nxt;
  logic [OFFS_W-1:0]  room_r, room_nxt;
  logic [OFFS_W-1:0]  rem_r, rem_nxt;
  logic [SIZE_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [EBANK_W-1:0] ebank_r, ebank_nxt;
  logic [OFFS_W-1:0]  eoff_r, eoff_nxt;

  // result waiting for the output register
  status_t            res_status_r, res_status_nxt;
  logic [OFFS_W-1:0]  res_off_r, res_off_nxt;
  logic [BANK_W-1:0]  res_bank_r, res_bank_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [OFFS_W-1:0]  out_off_r, out_off_nxt;
  logic [BANK_W-1:0]  out_bank_r, out_bank_nxt;

  // divider step
  logic [OFFS_W:0]    div_part;
  logic               div_ge;
  logic [OFFS_W-1:0]  div_rem;

  // end-position helpers
  logic [OFFS_W-1:0]  prep_bw;
  logic [OFFS_W-1:0]  prep_soff;
  logic [EBANK_W-1:0] fin_last;

  logic in_xfer;
  logic out_xfer;

  assign in_req.ready  = (state_r == S_IDLE);
  assign in_xfer       = in_req.valid && in_req.ready;
  assign out_xfer      = out_valid_r && out_rsp.ready;

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.status       = out_status_r;
  assign out_rsp.block_offset = out_off_r;
  assign out_rsp.block_bank   = out_bank_r;

  // one divider step: shift in the next dividend bit, subtract bank size if it fits
  assign div_part = {rem_r, quo_r[SIZE_W-1]};
  assign div_ge   = (div_part >= {1'b0, bw_r});
  assign div_rem  = div_ge ? OFFS_W'(div_part - {1'b0, bw_r}) : div_part[OFFS_W-1:0];

  // a bank size below two acts as two; offset zero is never handed out
  assign prep_bw   = (bank_size_r < BANK_SIZE_MIN) ? BANK_SIZE_MIN : bank_size_r;
  assign prep_soff = (offset_r == '0) ? OFFS_W'(1) : offset_r;

  // last word used: an end offset of zero means the block ended on a bank boundary
  assign fin_last = (eoff_r == '0) ? (ebank_r - EBANK_W'(1)) : ebank_r;

  always_comb begin
    state_nxt      = state_r;
    bank_size_nxt  = bank_size_r;
    first_bank_nxt = first_bank_r;
    last_bank_nxt  = last_bank_r;
    bank_nxt       = bank_r;
    offset_nxt     = offset_r;
    started_nxt    = started_r;
    op_nxt         = op_r;
    size_nxt       = size_r;
    count_nxt      = count_r;
    prod_nxt       = prod_r;
    bw_nxt         = bw_r;
    soff_nxt       = soff_r;
    room_nxt       = room_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    cnt_nxt        = cnt_r;
    ebank_nxt      = ebank_r;
    eoff_nxt       = eoff_r;
    res_status_nxt = res_status_r;
    res_off_nxt    = res_off_r;
    res_bank_nxt   = res_bank_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_off_nxt    = out_off_r;
    out_bank_nxt   = out_bank_r;

    // config writes, taken any time
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_BANK_SIZE:  bank_size_nxt  = cfg_wdata;
        CFG_FIRST_BANK: first_bank_nxt = cfg_wdata[BANK_W-1:0];
        CFG_LAST_BANK:  last_bank_nxt  = cfg_wdata[BANK_W-1:0];
        default: ;
      endcase
    end

    if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          op_nxt    = in_req.operation;
          size_nxt  = in_req.elem_size;
          count_nxt = in_req.elem_count;
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        res_off_nxt  = '0;
        res_bank_nxt = '0;
        if (op_r == OP_PLAIN) begin
          // a plain request starts the heap even when its size is zero
          if (!started_r) begin
            bank_nxt    = NBANK_W'(first_bank_r);
            offset_nxt  = '0;
            started_nxt = 1'b1;
          end
          if (size_r == '0) begin
            res_status_nxt = ST_ZERO;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_PREP;
          end
        end else if (size_r == '0 || count_r == '0) begin
          res_status_nxt = ST_ZERO;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_MUL;
        end
      end

      S_MUL: begin
        prod_nxt  = size_r * count_r;
        state_nxt = S_MCHK;
      end

      S_MCHK: begin
        if (prod_r[PROD_W-1:SIZE_W] != '0) begin
          res_status_nxt = ST_OVERFLOW;
          state_nxt      = S_DONE;
        end else begin
          if (!started_r) begin
            bank_nxt    = NBANK_W'(first_bank_r);
            offset_nxt  = '0;
            started_nxt = 1'b1;
          end
          size_nxt  = prod_r[SIZE_W-1:0];
          state_nxt = S_PREP;
        end
      end

      S_PREP: begin
        bw_nxt   = prep_bw;
        soff_nxt = prep_soff;
        // past the bank end after a smaller bank size: whole block goes to the next bank
        room_nxt = (prep_soff < prep_bw) ? (prep_bw - prep_soff) : '0;
        if (bank_r > {1'b0, last_bank_r}) begin
          res_status_nxt = ST_EXHAUSTED;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_BUMP;
        end
      end

      S_BUMP: begin
        if (size_r < SIZE_W'(room_r)) begin
          ebank_nxt = EBANK_W'(bank_r);
          eoff_nxt  = soff_r + size_r[OFFS_W-1:0];
          state_nxt = S_FIN;
        end else if (size_r == SIZE_W'(room_r)) begin
          ebank_nxt = EBANK_W'(bank_r) + EBANK_W'(1);
          eoff_nxt  = '0;
          state_nxt = S_FIN;
        end else begin
          // words left past the current bank go through the divider
          quo_nxt   = size_r - SIZE_W'(room_r);
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end

      S_DIV: begin
        rem_nxt = div_rem;
        quo_nxt = {quo_r[SIZE_W-2:0], div_ge};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(SIZE_W - 1)) begin
          state_nxt = S_QUO;
        end
      end

      S_QUO: begin
        ebank_nxt = EBANK_W'(bank_r) + EBANK_W'(quo_r) + EBANK_W'(1);
        eoff_nxt  = rem_r;
        state_nxt = S_FIN;
      end

      S_FIN: begin
        if (fin_last > EBANK_W'(last_bank_r)) begin
          res_status_nxt = ST_EXHAUSTED;
        end else begin
          res_status_nxt = ST_GRANTED;
          res_off_nxt    = soff_r;
          res_bank_nxt   = bank_r[BANK_W-1:0];
          bank_nxt       = ebank_r[NBANK_W-1:0];
          offset_nxt     = eoff_r;
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        // load once the output register is free or drains this cycle
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_off_nxt    = res_off_r;
          out_bank_nxt   = res_bank_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      bank_size_r  <= BANK_SIZE_RST;
      first_bank_r <= FIRST_BANK_RST;
      last_bank_r  <= LAST_BANK_RST;
      bank_r       <= '0;
      offset_r     <= '0;
      started_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      bank_size_r  <= bank_size_nxt;
      first_bank_r <= first_bank_nxt;
      last_bank_r  <= last_bank_nxt;
      bank_r       <= bank_nxt;
      offset_r     <= offset_nxt;
      started_r    <= started_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    size_r       <= size_nxt;
    count_r      <= count_nxt;
    prod_r       <= prod_nxt;
    bw_r         <= bw_nxt;
    soff_r       <= soff_nxt;
    room_r       <= room_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    cnt_r        <= cnt_nxt;
    ebank_r      <= ebank_nxt;
    eoff_r       <= eoff_nxt;
    res_status_r <= res_status_nxt;
    res_off_r    <= res_off_nxt;
    res_bank_r   <= res_bank_nxt;
    out_status_r <= out_status_nxt;
    out_off_r    <= out_off_nxt;
    out_bank_r   <= out_bank_nxt;
  end

  // a granted block never starts at word zero
  a_grant_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_GRANTED) |-> (out_off_r != '0))
    else $error("granted block at offset zero");

  // refused requests report a zero position
  a_refuse_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_GRANTED) |-> (out_off_r == '0 && out_bank_r == '0))
    else $error("refused request with nonzero position");

  // the position never runs more than one bank past the largest last bank
  a_bank_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bank_r <= NBANK_W'(256))
    else $error("next bank beyond heap range");

  // a request transfer always moves the sequencer to the checks
  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_CHECK))
    else $error("request transfer did not start the sequence");

  // the divider exits only after its last step
  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r != CNT_W'(SIZE_W - 1)) |=> (state_r == S_DIV))
    else $error("divider left early");

endmodule

FILE: verif/bba_alloc_checker.sv
`timescale 1ns / 1ps

module bba_alloc_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  bba_req_if                        req,
  bba_rsp_if                        rsp,
  input  logic                      cfg_we,
  input  bba_pkg::cfg_idx_t         cfg_index,
  input  logic [bba_pkg::CFG_W-1:0] cfg_wdata,
  output int                        mismatches,
  output int                        pending
);
  import bba_pkg::*;

  typedef struct packed {
    status_t           status;
    logic [OFFS_W-1:0] offset;
    logic [BANK_W-1:0] bank;
  } grant_t;

  logic [OFFS_W-1:0]  bank_size;
  logic [BANK_W-1:0]  first_bank;
  logic [BANK_W-1:0]  last_bank;
  logic [NBANK_W-1:0] cur_bank;
  logic [OFFS_W-1:0]  cur_offset;
  logic               heap_open;
  grant_t             grant_q[$];
  int                 errs = 0;

  // heap position is loaded on first use only
  function automatic void open_heap();
    if (!heap_open) begin
      cur_bank   = NBANK_W'(first_bank);
      cur_offset = '0;
      heap_open  = 1'b1;
    end
  endfunction

  function automatic grant_t bump_position(input logic [63:0] words);
    grant_t      g;
    logic [63:0] span;
    logic [63:0] sbank;
    logic [63:0] soff;
    logic [63:0] room;
    logic [63:0] ebank;
    logic [63:0] eoff;
    logic [63:0] tail_bank;
    g     = '0;
    span  = 64'((bank_size < BANK_SIZE_MIN) ? BANK_SIZE_MIN : bank_size);
    sbank = 64'(cur_bank);
    soff  = (cur_offset == '0) ? 64'd1 : 64'(cur_offset);
    room  = (soff < span) ? span - soff : 64'd0;
    if (words < room) begin
      ebank = sbank;
      eoff  = soff + words;
    end else if (words == room) begin
      ebank = sbank + 64'd1;
      eoff  = 64'd0;
    end else begin
      ebank = sbank + 64'd1 + (words - room) / span;
      eoff  = (words - room) % span;
    end
    tail_bank = (eoff == 64'd0) ? ebank - 64'd1 : ebank;
    if (sbank > last_bank || tail_bank > last_bank) begin
      g.status = ST_EXHAUSTED;
    end else begin
      cur_bank   = ebank[NBANK_W-1:0];
      cur_offset = eoff[OFFS_W-1:0];
      g.status   = ST_GRANTED;
      g.offset   = soff[OFFS_W-1:0];
      g.bank     = sbank[BANK_W-1:0];
    end
    return g;
  endfunction

  function automatic grant_t predict_grant(input op_t op, input logic [SIZE_W-1:0] req_size,
                                           input logic [SIZE_W-1:0] req_count);
    grant_t      g;
    logic [63:0] words;
    g     = '0;
    words = {32'd0, req_size} * {32'd0, req_count};
    if (op == OP_PLAIN) begin
      open_heap();
      if (req_size == '0) g.status = ST_ZERO;
      else g = bump_position({32'd0, req_size});
    end else if (req_size == '0 || req_count == '0) begin
      g.status = ST_ZERO;
    end else if (words[63:32] != '0) begin
      g.status = ST_OVERFLOW;
    end else begin
      open_heap();
      g = bump_position(words);
    end
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t want;
    if (!rst_n) begin
      bank_size  = BANK_SIZE_RST;
      first_bank = FIRST_BANK_RST;
      last_bank  = LAST_BANK_RST;
      cur_bank   = '0;
      cur_offset = '0;
      heap_open  = 1'b0;
      grant_q.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (grant_q.size() == 0) begin
          errs++;
          $display("%0t: result with none expected: status %0d offset %0d bank %0d",
                   $time, rsp.status, rsp.block_offset, rsp.block_bank);
        end else begin
          want = grant_q.pop_front();
          if (rsp.status !== want.status) begin
            errs++;
            $display("%0t: status expected %0d got %0d", $time, want.status, rsp.status);
          end
          if (rsp.block_offset !== want.offset) begin
            errs++;
            $display("%0t: block_offset expected %0d got %0d",
                     $time, want.offset, rsp.block_offset);
          end
          if (rsp.block_bank !== want.bank) begin
            errs++;
            $display("%0t: block_bank expected %0d got %0d", $time, want.bank, rsp.block_bank);
          end
        end
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BANK_SIZE:  bank_size  = cfg_wdata[OFFS_W-1:0];
          CFG_FIRST_BANK: first_bank = cfg_wdata[BANK_W-1:0];
          CFG_LAST_BANK:  last_bank  = cfg_wdata[BANK_W-1:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready)
        grant_q.push_back(predict_grant(op_t'(req.operation), req.elem_size, req.elem_count));
    end
    mismatches <= errs;
    pending    <= grant_q.size();
  end

endmodule

FILE: verif/banked_bump_allocator_core_tb.sv
`timescale 1ns / 1ps

module banked_bump_allocator_core_tb;
  import bba_pkg::*;

  // cycles with no transfer of any kind before the run is called hung
  localparam int WATCHDOG_CYCLES = 5000;
  // long receiver hold-off so the block backs up into its request side
  localparam int HOLD_CYCLES     = 300;
  // margin left after the last result before the final check
  localparam int DRAIN_CYCLES    = 60;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  cfg_idx_t         cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  bba_req_if req_bus ();
  bba_rsp_if rsp_bus ();

  int          mismatches;
  int          pending;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          stall_cycles = 0;
  int          hold_left;
  logic        hold_toggle;
  logic        hold_seen;
  // words per bank as the block uses it (values below 2 act as 2), for sizing requests
  int unsigned bank_span;

  banked_bump_allocator_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_bus),
    .out_rsp   (rsp_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  bba_alloc_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req_bus),
    .rsp        (rsp_bus),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random back-pressure, plus a long hold-off whenever the
  // stimulus flips hold_toggle; the hold is counted here, not by the sender
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_bus.ready <= 1'b0;
      hold_left     <= 0;
      hold_seen     <= 1'b0;
    end else if (hold_seen != hold_toggle) begin
      hold_seen     <= hold_toggle;
      hold_left     <= HOLD_CYCLES;
      rsp_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // watchdog: any request, result or register transfer restarts the count
  always @(posedge clk) begin
    if (!rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
        || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_CYCLES) begin
      $display("banked_bump_allocator_core_tb: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // one request transfer; valid stays high on return so back-to-back
  // requests never drop it within a time step
  task automatic send_request(input op_t op, input logic [SIZE_W-1:0] req_size,
                              input logic [SIZE_W-1:0] req_count);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    req_bus.valid      <= 1'b1;
    req_bus.operation  <= op;
    req_bus.elem_size  <= req_size;
    req_bus.elem_count <= req_count;
    do @(posedge clk); while (!req_bus.ready);
  endtask

  // stop offering and wait until every expected result has been seen
  task automatic settle();
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // only called with the block idle; the spare index is written too, it must be ignored,
  // and the upper byte of the bank registers carries junk that must be dropped
  task automatic program_regs(input logic [OFFS_W-1:0] words_per_bank,
                              input logic [BANK_W-1:0] first, input logic [BANK_W-1:0] last);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BANK_SIZE;
    cfg_wdata <= words_per_bank;
    @(posedge clk);
    cfg_index <= CFG_FIRST_BANK;
    cfg_wdata <= {8'($urandom), first};
    @(posedge clk);
    cfg_index <= CFG_LAST_BANK;
    cfg_wdata <= {8'($urandom), last};
    @(posedge clk);
    cfg_index <= CFG_UNUSED;
    cfg_wdata <= 16'($urandom);
    @(posedge clk);
    cfg_we    <= 1'b0;
    bank_span = (words_per_bank < 2) ? 2 : words_per_bank;
  endtask

  // mostly well-formed requests sized against the bank, so the heap lasts
  // through the run; the rest are zero operands, overflows and raw noise
  task automatic send_random();
    int unsigned pick;
    int unsigned little;
    int unsigned elem_cap;
    pick     = $urandom_range(0, 99);
    little   = (bank_span >= 16) ? bank_span / 8 : 1;
    elem_cap = (bank_span >= 128) ? bank_span / 64 : 1;
    if (pick < 52) begin
      send_request(OP_PLAIN, $urandom_range(1, little), $urandom);
    end else if (pick < 58) begin
      // crosses one or two bank boundaries
      send_request(OP_PLAIN, $urandom_range(bank_span, 2 * bank_span), $urandom);
    end else if (pick < 78) begin
      send_request(OP_ARRAY, $urandom_range(1, elem_cap), $urandom_range(1, 16));
    end else if (pick < 84) begin
      // both operands at least 2^16, product cannot fit 32 bits
      send_request(OP_ARRAY, $urandom_range(32'h10000, 32'hFFFFFFFF),
                   $urandom_range(32'h10000, 32'hFFFFFFFF));
    end else if (pick < 90) begin
      case ($urandom_range(0, 2))
        0:       send_request(OP_PLAIN, '0, $urandom);
        1:       send_request(OP_ARRAY, '0, $urandom);
        default: send_request(OP_ARRAY, $urandom, '0);
      endcase
    end else begin
      send_request(op_t'($urandom_range(0, 1)), $urandom, $urandom);
    end
  endtask

  task automatic run_allocs(input int n, input int pause_at);
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) settle();
      send_random();
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_BANK_SIZE;
    cfg_wdata          = '0;
    req_bus.valid      = 1'b0;
    req_bus.operation  = OP_PLAIN;
    req_bus.elem_size  = '0;
    req_bus.elem_count = '0;
    hold_toggle        = 1'b0;
    send_idle_pct      = 18;
    recv_idle_pct      = 69;
    bank_span          = BANK_SIZE_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // refused array requests before any plain one: these must not open the heap
    send_request(OP_ARRAY, '0, 32'd5);
    send_request(OP_ARRAY, 32'd3, '0);
    send_request(OP_ARRAY, '0, '0);
    send_request(OP_ARRAY, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_request(OP_ARRAY, 32'h10000, 32'h10000);     // product exactly 2^32
    settle();
    // moving the first bank now shows whether the heap was opened too early
    program_regs(16'd64000, 8'd0, 8'd255);
    send_request(OP_PLAIN, '0, 32'hFFFFFFFF);          // zero size still opens the heap
    send_request(OP_PLAIN, 32'd1, '0);                 // offset zero moved up to one
    send_request(OP_ARRAY, 32'h0000FFFF, 32'h00010001); // largest product, no overflow
    send_request(OP_PLAIN, 32'hFFFFFFFF, 32'd7);
    send_request(OP_PLAIN, 32'd63998, 32'd1);          // fills the bank exactly
    send_request(OP_PLAIN, 32'd1, 32'd0);
    send_request(OP_PLAIN, 32'd128005, 32'd0);         // spans two bank boundaries
    send_request(OP_ARRAY, 32'd7, 32'd9);
    send_request(OP_ARRAY, 32'd100, 32'd1);
    settle();
    // heap ends at the current bank
    program_regs(16'd64000, 8'd0, 8'd3);
    send_request(OP_PLAIN, 32'd63831, 32'd0);          // one word into a bank past the end
    send_request(OP_PLAIN, 32'd63830, 32'd0);          // ends exactly on the last bank
    send_request(OP_PLAIN, 32'd1, 32'd0);              // position already past the end
    settle();
    // bank size below the minimum acts as two words
    program_regs(16'd0, 8'd0, 8'd255);
    send_request(OP_PLAIN, 32'd1, 32'd0);
    send_request(OP_ARRAY, 32'd3, 32'd1);
    settle();
    program_regs(16'd1, 8'd0, 8'd255);
    send_request(OP_PLAIN, 32'd2, 32'd0);
    settle();
    program_regs(16'hFFFF, 8'd0, 8'd255);
    send_request(OP_PLAIN, 32'd5000, 32'd0);
    settle();
    // offset now far beyond the shrunk bank: whole block goes to the next bank
    program_regs(16'd16, 8'd0, 8'd255);
    send_request(OP_PLAIN, 32'd3, 32'd0);

    // sender lightly idle, receiver heavily idle; one full drain midway
    settle();
    program_regs(16'hFFFF, 8'd255, 8'd255);
    run_allocs(250, 120);

    // roles swapped; the smaller bank leaves the offset past its end
    settle();
    send_idle_pct = 69;
    recv_idle_pct = 18;
    program_regs(16'd1000, 8'd7, 8'd255);
    run_allocs(250, -1);

    // last bank zero, everything that gets past the operand checks is refused
    settle();
    program_regs(16'd0, 8'd0, 8'd0);
    run_allocs(30, -1);

    // no idling; long result hold-off right away so the request side stalls
    settle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_regs(16'd300, 8'd0, 8'd255);
    hold_toggle <= ~hold_toggle;
    run_allocs(180, -1);

    // tiny banks burn through what is left of the heap
    settle();
    program_regs(16'd1, 8'd3, 8'd255);
    run_allocs(120, -1);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("banked_bump_allocator_core_tb: done, clean");
    else
      $display("banked_bump_allocator_core_tb: done, errors");
    $finish;
  end

endmodule
